// ===== hw/rtl/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg
// Shared widths, request codes and register map of the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

	// fixed line capacity; column and length fields follow from it
	localparam int LINE_CAPACITY = 256;

	localparam int REQ_W  = 3;
	localparam int CHAR_W = 8;
	localparam int POS_W  = $clog2(LINE_CAPACITY + 1);

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	// request codes; codes 5..7 are refused
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT     = 3'd0,
		REQ_OVERWRITE  = 3'd1,
		REQ_DELETE     = 3'd2,
		REQ_SET_CURSOR = 3'd3,
		REQ_READ       = 3'd4
	} req_code_t;

	// APB register map: one 32-bit register per word
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index = paddr[APB_ADDR_W-1]
	localparam logic REG_READ_ONLY = 1'b0;

endpackage

// ===== hw/rtl/leb_ifs.sv =====
// ----------------------------------------------------------------------------
// leb_req_if / leb_rsp_if
// Valid/ready channels for edit requests and their results.
// ----------------------------------------------------------------------------
interface leb_req_if import leb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] char_in;
	logic [POS_W-1:0]  position;

	modport source (output valid, req_type, char_in, position, input ready);
	modport sink (input valid, req_type, char_in, position, output ready);
endinterface

interface leb_rsp_if import leb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [CHAR_W-1:0] char_out;
	logic [POS_W-1:0]  cursor_out;
	logic [POS_W-1:0]  length_out;

	modport source (output valid, ok, char_out, cursor_out, length_out, input ready);
	modport sink (input valid, ok, char_out, cursor_out, length_out, output ready);
endinterface

// ===== hw/rtl/leb_line_ram.sv =====
// ----------------------------------------------------------------------------
// leb_line_ram
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module leb_line_ram import leb_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer
// Single-line text edit buffer with a cursor column, built around one
// character memory and a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one request item at a time and returns exactly one result
// item for it. Cursor moves, reads, refused edits and an overwrite inside
// the line go from idle straight to the commit state. An insert inside the
// line and a delete move the tail one character per cycle through the line
// memory's single write port; an insert with the cursor at the end of the
// line and a delete of the last character have no tail to move. An insert
// past the end pads the gap with spaces at one cell per cycle. The commit
// state loads the result into the output register and waits while that
// register is full. A new request is taken as soon as the sequencer is back
// in idle, even while the previous result still waits in the output
// register. There is no clearing pass after reset: every cell at or past
// the current length reads as a space by a compare against the length, and
// every cell below the length has been written since reset.
// read_only is bit 0 at paddr[2] == 0; writes elsewhere are ignored.
// ----------------------------------------------------------------------------
module line_edit_buffer import leb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	leb_req_if.sink               req,
	leb_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// CW holds 0..LINE_CAPACITY, AW indexes the memory
	localparam int CW = $clog2(LINE_CAPACITY + 1);
	localparam int AW = $clog2(LINE_CAPACITY);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,  // fill gap with spaces, then the character
		ST_MOVE = 4'b0100,  // shift tail right (insert) or left (delete)
		ST_FIN  = 4'b1000   // wait for the output register, commit
	} state_t;

	state_t state_q, state_d;

	// architectural state
	logic [CW-1:0] len_q;
	logic [CW-1:0] cur_q;
	logic          ro_q;

	// per-request working registers
	logic [CHAR_W-1:0] ch_q;
	logic              ok_q;
	logic [CW-1:0]     new_len_q;
	logic [CW-1:0]     new_cur_q;
	logic              from_mem_q;  // result char comes from the memory read
	logic              blank_q;     // read past the end: result is a space
	logic              right_q;     // shift direction
	logic              ins_q;       // store the character after the shift
	logic [CW-1:0]     rem_q;       // tail reads still to issue
	logic [AW-1:0]     ptr_q;       // read pointer (move) / write pointer (pad)

	// one move in flight: read issued last cycle, write this cycle
	logic          wpend_s1;
	logic [AW-1:0] waddr_s1;

	// result register
	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [CHAR_W-1:0] rsp_char_q;
	logic [POS_W-1:0]  rsp_cur_q;
	logic [POS_W-1:0]  rsp_len_q;

	// memory ports
	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [CHAR_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	logic [CHAR_W-1:0] mem_rd_data;

	leb_line_ram #(
		.DEPTH (LINE_CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// ------------------------------------------------------------------
	// Request decode (evaluated in idle)
	// ------------------------------------------------------------------
	logic          req_fire;
	logic          past_end;
	logic [CW-1:0] top;
	logic [CW-1:0] cur_inc;
	logic          ins_fits;
	logic          do_ins;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cap_x;

	logic          dec_ok;
	logic [CW-1:0] dec_len;
	logic [CW-1:0] dec_cur;
	state_t        dec_state;
	logic          dec_right;
	logic          dec_ins;
	logic [CW-1:0] dec_rem;
	logic [AW-1:0] dec_ptr;
	logic          dec_wr;     // overwrite inside the line: write at once
	logic          dec_rd;     // read request inside the line
	logic          dec_blank;

	assign req_fire = (state_q == ST_IDLE) && req.valid;
	assign past_end = cur_q > len_q;
	assign top      = past_end ? cur_q : len_q;
	assign cur_inc  = cur_q + CW'(1);
	assign ins_fits = top < CW'(LINE_CAPACITY);
	assign do_ins   = !ro_q && ins_fits
		&& ((req.req_type == REQ_INSERT) || past_end);
	assign pos_x    = XW'(req.position);
	assign cap_x    = XW'(LINE_CAPACITY);

	always_comb begin
		dec_ok    = 1'b0;
		dec_len   = len_q;
		dec_cur   = cur_q;
		dec_state = ST_FIN;
		dec_right = 1'b0;
		dec_ins   = 1'b0;
		dec_rem   = '0;
		dec_ptr   = '0;
		dec_wr    = 1'b0;
		dec_rd    = 1'b0;
		dec_blank = 1'b0;
		unique case (req.req_type) inside
			REQ_INSERT, REQ_OVERWRITE: begin
				if (do_ins) begin
					dec_ok  = 1'b1;
					dec_cur = cur_inc;
					dec_len = top + CW'(1);
					dec_ins = 1'b1;
					if (past_end) begin
						dec_state = ST_PAD;
						dec_ptr   = AW'(len_q);
					end else begin
						dec_state = ST_MOVE;
						dec_right = 1'b1;
						dec_rem   = len_q - cur_q;
						dec_ptr   = AW'(len_q - CW'(1));
					end
				end else if ((req.req_type == REQ_OVERWRITE) && !ro_q && !past_end
						&& (cur_q < CW'(LINE_CAPACITY))) begin
					dec_ok  = 1'b1;
					dec_wr  = 1'b1;
					dec_cur = cur_inc;
					dec_len = (cur_inc > len_q) ? cur_inc : len_q;
				end
			end
			REQ_DELETE: begin
				if (!ro_q && (cur_q < len_q)) begin
					dec_ok    = 1'b1;
					dec_len   = len_q - CW'(1);
					dec_state = ST_MOVE;
					dec_rem   = len_q - cur_q - CW'(1);
					dec_ptr   = AW'(cur_inc);
				end
			end
			REQ_SET_CURSOR: begin
				dec_ok  = 1'b1;
				dec_cur = (pos_x > cap_x) ? CW'(LINE_CAPACITY) : CW'(req.position);
			end
			REQ_READ: begin
				if (pos_x < cap_x) begin
					dec_ok = 1'b1;
					// cells at or past the length are always spaces
					if (pos_x < XW'(len_q)) begin
						dec_rd = 1'b1;
					end else begin
						dec_blank = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic move_issue;
	logic move_done;
	logic pad_last;
	logic out_free;

	assign move_issue = (state_q == ST_MOVE) && (rem_q != '0);
	assign move_done  = (state_q == ST_MOVE) && (rem_q == '0) && !wpend_s1;
	assign pad_last   = ptr_q == AW'(cur_q);
	assign out_free   = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = dec_state;
				end
			end
			ST_PAD: begin
				if (pad_last) begin
					state_d = ST_FIN;
				end
			end
			ST_MOVE: begin
				if (move_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory port selection
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(cur_q);
		mem_wr_data = ch_q;
		if (req_fire && dec_rd) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = AW'(req.position);
		end else if (move_issue) begin
			mem_rd_en = 1'b1;
		end

		if (req_fire && dec_wr) begin
			mem_wr_en   = 1'b1;
			mem_wr_data = req.char_in;
		end else if (state_q == ST_PAD) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = ptr_q;
			mem_wr_data = pad_last ? ch_q : BLANK_CHAR;
		end else if ((state_q == ST_MOVE) && wpend_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = waddr_s1;
			mem_wr_data = mem_rd_data;
		end else if (move_done && ins_q) begin
			// character lands in the freed cell at the cursor
			mem_wr_en = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			ro_q        <= 1'b0;
			rem_q       <= '0;
			wpend_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_READ_ONLY)) begin
				ro_q <= pwdata[0];
			end

			if (req_fire) begin
				rem_q <= dec_rem;
			end else if (move_issue) begin
				rem_q <= rem_q - CW'(1);
			end

			wpend_s1 <= move_issue;

			if ((state_q == ST_FIN) && out_free) begin
				len_q       <= new_len_q;
				cur_q       <= new_cur_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ch_q       <= req.char_in;
			ok_q       <= dec_ok;
			new_len_q  <= dec_len;
			new_cur_q  <= dec_cur;
			from_mem_q <= dec_rd;
			blank_q    <= dec_blank;
			right_q    <= dec_right;
			ins_q      <= dec_ins;
			ptr_q      <= dec_ptr;
		end else if (state_q == ST_PAD) begin
			ptr_q <= ptr_q + AW'(1);
		end else if (move_issue) begin
			ptr_q <= right_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
		end

		if (move_issue) begin
			waddr_s1 <= right_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
		end

		if ((state_q == ST_FIN) && out_free) begin
			rsp_ok_q  <= ok_q;
			rsp_char_q <= from_mem_q ? mem_rd_data : (blank_q ? BLANK_CHAR : '0);
			rsp_cur_q <= POS_W'(new_cur_q);
			rsp_len_q <= POS_W'(new_len_q);
		end
	end

	// ------------------------------------------------------------------
	// Ports
	// ------------------------------------------------------------------
	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.char_out   = rsp_char_q;
	assign rsp.cursor_out = rsp_cur_q;
	assign rsp.length_out = rsp_len_q;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == REG_READ_ONLY) ? APB_DATA_W'(ro_q) : '0;

endmodule

// ===== hw/rtl/leb_checker.sv =====
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks of the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker import leb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_ok,
	input logic [CHAR_W-1:0] rsp_char_out,
	input logic [POS_W-1:0]  rsp_cursor_out,
	input logic [POS_W-1:0]  rsp_length_out
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_ok, rsp_char_out, rsp_cursor_out, rsp_length_out}))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while busy");

	// a new result frees the request side in the same cycle
	a_rsp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result shown while sequencer busy");

	// refused requests carry no character
	a_refused_char: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_char_out == '0)
		else $error("refused item with nonzero char_out");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_char_out   (rsp.char_out),
	.rsp_cursor_out (rsp.cursor_out),
	.rsp_length_out (rsp.length_out)
);

// ===== tb/sv/line_edit_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_edit_buffer_tb
// Self-checking bench for the line edit buffer. A directed opening covers
// empty and full lines, padding past the end, saturating cursor moves,
// out-of-range reads, unknown request codes and the read-only lock. A
// randomized body of edits, cursor moves and reads follows, with random
// gaps on both channels and one long receiver hold that backs up the input.
// Every result item is compared field by field against a shadow copy of the
// line that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module line_edit_buffer_tb;
	import leb_pkg::*;

	localparam int LINE_CAP    = LINE_CAPACITY;
	// longest quiet span: a full-line shift behind the long receiver hold,
	// plus the longest random gaps; taken ~4x
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 600;
	localparam int PRINT_CAP   = 40;

	// unassigned request codes, refused by the block
	localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

	localparam logic [APB_ADDR_W-1:0] RO_ADDR = {REG_READ_ONLY, 2'b00};

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [CHAR_W-1:0] char_in;
		logic [POS_W-1:0]  position;
	} keystroke_t;

	typedef struct packed {
		logic              ok;
		logic [CHAR_W-1:0] char_out;
		logic [POS_W-1:0]  cursor_out;
		logic [POS_W-1:0]  length_out;
	} line_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic                  pready;

	leb_req_if keys ();
	leb_rsp_if status ();

	line_edit_buffer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (keys),
		.rsp     (status),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// shadow copy of the line, cursor, length and lock
	logic [CHAR_W-1:0] shadow_line [LINE_CAP];
	int unsigned       shadow_len, shadow_cur;
	logic              shadow_ro;

	keystroke_t   keystroke_q[$];   // requests not yet offered
	line_status_t line_status_q[$]; // results owed by the block, oldest first

	// run-control flags shared between processes
	logic no_idle;      // both sides stop idling while set
	logic hold_go;      // kicks off the long receiver hold
	logic status_hold;  // receiver held off

	int send_gap, recv_gap;
	int mismatch_count;
	int keys_taken, results_seen;
	int edits_applied, edits_refused, reads_outside, full_line_hits;

	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		if (mismatch_count < PRINT_CAP)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// random idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Line predictor
	// ------------------------------------------------------------------------
	// insert at the cursor: pad with blanks when past the end, else open a
	// cell by moving the tail right; refused if cursor or length hits capacity
	function automatic bit put_char(logic [CHAR_W-1:0] ch);
		int unsigned top, i;
		top = (shadow_cur > shadow_len) ? shadow_cur : shadow_len;
		if (top + 1 > LINE_CAP)
			return 1'b0;
		if (shadow_cur > shadow_len) begin
			for (i = shadow_len; i < shadow_cur; i++)
				shadow_line[i] = BLANK_CHAR;
		end else begin
			for (i = shadow_len; i > shadow_cur; i--)
				shadow_line[i] = shadow_line[i - 1];
		end
		shadow_line[shadow_cur] = ch;
		shadow_cur = shadow_cur + 1;
		shadow_len = top + 1;
		return 1'b1;
	endfunction

	function automatic line_status_t apply_edit(keystroke_t k);
		line_status_t s;
		int unsigned i;
		bit is_edit;
		s = '0;
		is_edit = 1'b0;
		case (k.req_type)
		REQ_INSERT: begin
			is_edit = 1'b1;
			if (!shadow_ro)
				s.ok = put_char(k.char_in);
		end
		REQ_OVERWRITE: begin
			is_edit = 1'b1;
			if (!shadow_ro) begin
				if (shadow_cur > shadow_len) begin
					s.ok = put_char(k.char_in);
				end else if (shadow_cur + 1 <= LINE_CAP) begin
					// replace in place, grow only when writing at the end
					shadow_line[shadow_cur] = k.char_in;
					shadow_cur = shadow_cur + 1;
					if (shadow_cur > shadow_len)
						shadow_len = shadow_cur;
					s.ok = 1'b1;
				end
			end
		end
		REQ_DELETE: begin
			is_edit = 1'b1;
			if (!shadow_ro && shadow_cur < shadow_len) begin
				// close the gap, blank the freed cell; cursor stays put
				for (i = shadow_cur; i + 1 < shadow_len; i++)
					shadow_line[i] = shadow_line[i + 1];
				shadow_len = shadow_len - 1;
				shadow_line[shadow_len] = BLANK_CHAR;
				s.ok = 1'b1;
			end
		end
		REQ_SET_CURSOR: begin
			shadow_cur = (k.position > LINE_CAP) ? LINE_CAP : k.position;
			s.ok = 1'b1;
		end
		REQ_READ: begin
			if (k.position < LINE_CAP) begin
				s.char_out = shadow_line[k.position];
				s.ok = 1'b1;
			end else begin
				reads_outside++;
			end
		end
		default: ; // codes 5..7 are refused without effect
		endcase
		if (is_edit) begin
			if (s.ok)
				edits_applied++;
			else
				edits_refused++;
		end
		if (shadow_len == LINE_CAP)
			full_line_hits++;
		s.cursor_out = POS_W'(shadow_cur);
		s.length_out = POS_W'(shadow_len);
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: offers queued items with random gaps between them and
	// predicts the result as each item is accepted
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : key_driver
		keystroke_t taken, nk;
		logic       nxt_valid;
		if (!arst_n) begin
			keys.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			nxt_valid = keys.valid;
			if (keys.valid && keys.ready) begin
				taken.req_type = keys.req_type;
				taken.char_in = keys.char_in;
				taken.position = keys.position;
				line_status_q.push_back(apply_edit(taken));
				keys_taken++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (keystroke_q.size() != 0) begin
					nk = keystroke_q.pop_front();
					keys.req_type <= nk.req_type;
					keys.char_in <= nk.char_in;
					keys.position <= nk.position;
					nxt_valid = 1'b1;
					send_gap <= no_idle ? 0 : pick_gap();
				end
			end
			keys.valid <= nxt_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: random ready gaps, compare against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : status_checker
		line_status_t want;
		int           g;
		if (!arst_n) begin
			status.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			g = recv_gap;
			if (status.valid && status.ready) begin
				results_seen++;
				if (line_status_q.size() == 0) begin
					flag_mismatch("result with nothing pending", 0, 1);
				end else begin
					want = line_status_q.pop_front();
					if (status.ok !== want.ok)
						flag_mismatch("ok", want.ok, status.ok);
					if (status.char_out !== want.char_out)
						flag_mismatch("char_out", want.char_out, status.char_out);
					if (status.cursor_out !== want.cursor_out)
						flag_mismatch("cursor_out", want.cursor_out, status.cursor_out);
					if (status.length_out !== want.length_out)
						flag_mismatch("length_out", want.length_out, status.length_out);
				end
				g = no_idle ? 0 : pick_gap();
			end else if (g != 0) begin
				g = g - 1;
			end
			recv_gap <= g;
			status.ready <= (g == 0) && !status_hold;
		end
	end

	// long receiver hold so the block backs up and stalls its input
	initial begin : long_hold
		status_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		status_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		status_hold <= 1'b0;
	end

	// ends the run if nothing moves on either channel or the register port
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (keys.valid && keys.ready) || (status.valid && status.ready)
					|| (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout after %0d quiet cycles, %0d results owed",
			quiet_cycles, line_status_q.size());
		$display("line_edit_buffer test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_key(logic [REQ_W-1:0] r, logic [CHAR_W-1:0] c, logic [POS_W-1:0] p);
		keystroke_t k;
		k.req_type = r;
		k.char_in = c;
		k.position = p;
		keystroke_q.push_back(k);
	endtask

	// trim leans toward deletes near the start so the line shrinks again
	task automatic queue_random(int n, bit trim);
		keystroke_t k;
		int unsigned sel, band;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			band = $urandom_range(0, 9);
			k.char_in = CHAR_W'($urandom_range(0, 255));
			k.position = POS_W'($urandom_range(0, 511));
			if (sel < (trim ? 15 : 32)) begin
				k.req_type = REQ_INSERT;
			end else if (sel < (trim ? 30 : 52)) begin
				k.req_type = REQ_OVERWRITE;
			end else if (sel < (trim ? 70 : 70)) begin
				k.req_type = REQ_DELETE;
			end else if (sel < 83) begin
				k.req_type = REQ_SET_CURSOR;
				if (band < 6)
					k.position = POS_W'($urandom_range(0, trim ? 20 : 70));
				else if (band < 9)
					k.position = POS_W'($urandom_range(230, 256));
				else
					k.position = POS_W'($urandom_range(257, 511));
			end else if (sel < 95) begin
				k.req_type = REQ_READ;
				if (band < 6)
					k.position = POS_W'($urandom_range(0, 90));
				else if (band < 8)
					k.position = POS_W'($urandom_range(200, 255));
				else
					k.position = POS_W'($urandom_range(256, 511));
			end else begin
				k.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
			end
			keystroke_q.push_back(k);
		end
	endtask

	// wait until every queued item has been taken and answered
	task automatic drain();
		while (keystroke_q.size() != 0 || keys.valid || line_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write the lock register while idle, then read it back
	task automatic set_read_only(logic v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RO_ADDR;
		pwdata <= {{(APB_DATA_W-1){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		shadow_ro = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DATA_W-1){1'b0}}, v})
			flag_mismatch("read_only readback", v, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		arst_n = 1'b0;
		keys.valid = 1'b0;
		keys.req_type = '0;
		keys.char_in = '0;
		keys.position = '0;
		status.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_idle = 1'b0;
		hold_go = 1'b0;
		mismatch_count = 0;
		keys_taken = 0;
		results_seen = 0;
		edits_applied = 0;
		edits_refused = 0;
		reads_outside = 0;
		full_line_hits = 0;
		foreach (shadow_line[i])
			shadow_line[i] = BLANK_CHAR;
		shadow_len = 0;
		shadow_cur = 0;
		shadow_ro = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_read_only(1'b0);

		// directed: empty line, shifts, padding, range edges, full line
		queue_key(REQ_READ, 8'h00, 9'd0);          // blank after reset
		queue_key(REQ_DELETE, 8'h00, 9'd0);        // nothing to delete
		queue_key(REQ_INSERT, 8'h00, 9'd0);
		queue_key(REQ_INSERT, 8'hFF, 9'd0);
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd0);
		queue_key(REQ_INSERT, 8'h41, 9'd0);        // tail moves right
		queue_key(REQ_OVERWRITE, 8'h5A, 9'd0);     // in place
		queue_key(REQ_DELETE, 8'h00, 9'd0);        // last character goes, no tail to move
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd10);
		queue_key(REQ_INSERT, 8'h7E, 9'd0);        // pads the gap
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd20);
		queue_key(REQ_OVERWRITE, 8'h80, 9'd0);     // past the end acts as insert
		queue_key(REQ_OVERWRITE, 8'h7F, 9'd0);     // at the end, grows line
		queue_key(REQ_READ, 8'h00, 9'd15);         // padded blank
		queue_key(REQ_READ, 8'h00, 9'd255);
		queue_key(REQ_READ, 8'h00, 9'd256);        // beyond capacity
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd511);  // saturates
		queue_key(REQ_INSERT, 8'h33, 9'd0);        // no room past capacity
		queue_key(REQ_OVERWRITE, 8'h34, 9'd0);
		queue_key(REQ_BAD_LO, 8'hAA, 9'h1AA);
		queue_key(REQ_BAD_HI, 8'h55, 9'h055);
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd255);
		queue_key(REQ_INSERT, 8'h01, 9'd0);        // line now full
		queue_key(REQ_OVERWRITE, 8'h02, 9'd0);     // cursor at capacity
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd100);
		queue_key(REQ_INSERT, 8'h03, 9'd0);        // full line refuses insert
		queue_key(REQ_OVERWRITE, 8'h04, 9'd0);     // but allows overwrite
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd0);
		queue_key(REQ_DELETE, 8'h00, 9'd0);        // whole-line shift
		drain();

		// locked line: edits refused, moves and reads still served
		set_read_only(1'b1);
		queue_key(REQ_INSERT, 8'h61, 9'd0);
		queue_key(REQ_OVERWRITE, 8'h62, 9'd0);
		queue_key(REQ_DELETE, 8'h00, 9'd0);
		queue_key(REQ_SET_CURSOR, 8'h00, 9'd3);
		queue_key(REQ_READ, 8'h00, 9'd3);
		queue_random(60, 1'b0);
		drain();

		// unlocked, with the long receiver hold at the start
		set_read_only(1'b0);
		hold_go = 1'b1;
		queue_random(300, 1'b0);
		drain();

		// shrink the line back down
		queue_random(150, 1'b1);
		drain();

		set_read_only(1'b1);
		queue_random(40, 1'b0);
		drain();

		// back to editing; one stretch with no idling on either side
		set_read_only(1'b0);
		no_idle = 1'b1;
		queue_random(150, 1'b0);
		drain();
		no_idle = 1'b0;
		queue_random(100, 1'b1);
		queue_random(130, 1'b0);
		drain();

		// quiet tail to catch stray results
		no_idle = 1'b1;
		repeat (LINE_CAP + 8) @(posedge clk);

		$display("Ran %0d requests (%0d results): %0d edits applied, %0d refused.",
			keys_taken, results_seen, edits_applied, edits_refused);
		$display("Full line seen on %0d results, %0d reads past capacity, lock on and off.",
			full_line_hits, reads_outside);
		if (mismatch_count == 0) begin
			$display("line_edit_buffer test passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("line_edit_buffer test failed");
		end
		$finish;
	end

endmodule
